// File: hw/rtl/vm_conditional_branch_unit_defines.svh
// assertion macros used by the branch unit sequencer rtl
// expects clk and rst_n in the scope of each use
`ifndef VM_CONDITIONAL_BRANCH_UNIT_DEFINES_SVH
`define VM_CONDITIONAL_BRANCH_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define VMCBU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define VMCBU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/vmcbu_pkg.sv
// types, codes and helpers of the conditional branch unit
// no dependencies
package vmcbu_pkg;

  localparam int unsigned DATA_BYTES_DEF = 65536;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_JUMP  = 1'b1;

  localparam logic [1:0] MODE_IMM     = 2'd0;
  localparam logic [1:0] MODE_DIRECT  = 2'd1;
  localparam logic [1:0] MODE_IND_VAL = 2'd2;
  localparam logic [1:0] MODE_IND_TGT = 2'd3;

  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_HALF  = 2'd1;
  localparam logic [1:0] SIZE_WORD  = 2'd2;
  localparam logic [1:0] SIZE_DWORD = 2'd3;

  // fall-through instruction lengths
  localparam logic [3:0] FALL_LEN [4] = '{4'd4, 4'd5, 4'd7, 4'd11};
  localparam logic [3:0] FALL_LEN_IND = 4'd5;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  mode;
    logic [1:0]  size;
    logic [15:0] pc;
    logic [15:0] target;
    logic [63:0] operand;
    logic [15:0] write_addr;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        taken;
  } out_item_t;

  typedef struct packed {
    logic        en;
    logic [15:0] addr;
    logic [7:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic        en;
    logic [15:0] addr;
  } mem_rd_t;

  // address modulo depth, for addresses below 256 times depth, by greedy subtraction of depth shifted down from 2^7
  function automatic logic [15:0] wrap_addr(input logic [15:0] a, input int unsigned depth);
    logic [16:0] r;
    logic [16:0] step;
    r = {1'b0, a};
    for (int k = 7; k >= 0; k--) begin
      step = 17'(depth) << k;
      if (step != 17'd0 && r >= step) begin
        r = r - step;
      end
    end
    return r[15:0];
  endfunction

endpackage

// File: hw/rtl/vmcbu_mem.sv
// byte-wide data memory, one write port, one read port, registered read data
// depends on vmcbu_pkg
module vmcbu_mem #(
  parameter int unsigned DATA_BYTES = vmcbu_pkg::DATA_BYTES_DEF
) (
  input  logic              clk,
  input  vmcbu_pkg::mem_wr_t wr,
  input  vmcbu_pkg::mem_rd_t rd,
  output logic [7:0]        rd_data
);
  import vmcbu_pkg::*;

  localparam int unsigned AW = $clog2(DATA_BYTES);

  logic [7:0] mem_r [DATA_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr[AW-1:0]] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem_r[rd.addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/vmcbu_seq.sv
// jump sequencer: walks pointer, target and value bytes through the data memory
// depends on vmcbu_pkg and the assertion macro header
`include "vm_conditional_branch_unit_defines.svh"

module vmcbu_seq #(
  parameter int unsigned DATA_BYTES = vmcbu_pkg::DATA_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  vmcbu_pkg::in_item_t  item,
  input  logic [15:0]          code_offset,
  output logic                 busy,
  output vmcbu_pkg::mem_rd_t   rd,
  input  logic [7:0]           rd_data,
  output logic                 out_valid,
  output vmcbu_pkg::out_item_t out_item
);
  import vmcbu_pkg::*;

  localparam int unsigned AW = $clog2(DATA_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_PTR, S_PTR_HI, S_TGT, S_VAL, S_DRAIN, S_DONE
  } state_t;

  state_t      state_r;
  state_t      tag_st_r;
  logic        tag_vld_r;
  logic [2:0]  tag_idx_r;
  logic [2:0]  cnt_r;
  logic [AW-1:0] addr_r;
  logic [1:0]  mode_r;
  logic [1:0]  size_r;
  logic [15:0] pc_r;
  logic [15:0] target_r;
  logic [15:0] opaddr_r;
  logic [15:0] ptr_r;
  logic [15:0] dest_r;
  logic        nz_r;
  logic        out_valid_r;
  out_item_t   out_item_r;

  logic        rd_en;
  logic        imm_nz;
  logic [2:0]  last_idx;
  logic [15:0] op_w;
  logic [15:0] tgt_w;
  logic [15:0] ptr_w;
  logic [3:0]  fall_len;
  logic [AW-1:0] addr_inc;

  assign rd_en    = (state_r == S_PTR) || (state_r == S_TGT) || (state_r == S_VAL);
  assign last_idx = 3'((4'd1 << size_r) - 4'd1);
  assign op_w     = wrap_addr(opaddr_r, DATA_BYTES);
  assign tgt_w    = wrap_addr(target_r, DATA_BYTES);
  // pointer high byte forwarded straight from the read port
  assign ptr_w    = wrap_addr({rd_data, ptr_r[7:0]}, DATA_BYTES);
  assign addr_inc = (addr_r == AW'(DATA_BYTES - 1)) ? '0 : addr_r + 1'b1;
  assign fall_len = (mode_r == MODE_IMM) ? FALL_LEN[size_r] : FALL_LEN_IND;

  always_comb begin
    case (item.size)
      SIZE_BYTE: imm_nz = |item.operand[7:0];
      SIZE_HALF: imm_nz = |item.operand[15:0];
      SIZE_WORD: imm_nz = |item.operand[31:0];
      default:   imm_nz = |item.operand;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tag_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_DONE);
      tag_vld_r   <= rd_en;
      tag_st_r    <= state_r;
      tag_idx_r   <= cnt_r;

      // returning read data
      if (tag_vld_r) begin
        case (tag_st_r)
          S_PTR: begin
            if (tag_idx_r[0]) ptr_r[15:8] <= rd_data;
            else              ptr_r[7:0]  <= rd_data;
          end
          S_TGT: begin
            if (tag_idx_r[0]) dest_r[15:8] <= rd_data;
            else              dest_r[7:0]  <= rd_data;
          end
          S_VAL:   nz_r <= nz_r | (rd_data != 8'd0);
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (go) begin
            mode_r   <= item.mode;
            size_r   <= item.size;
            pc_r     <= item.pc;
            target_r <= item.target;
            opaddr_r <= item.operand[15:0];
            dest_r   <= item.target;
            cnt_r    <= 3'd0;
            if (item.mode == MODE_IMM) begin
              nz_r    <= imm_nz;
              state_r <= S_DONE;
            end else begin
              nz_r    <= 1'b0;
              state_r <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          cnt_r <= 3'd0;
          case (mode_r)
            MODE_DIRECT: begin
              addr_r  <= op_w[AW-1:0];
              state_r <= S_VAL;
            end
            MODE_IND_VAL: begin
              addr_r  <= op_w[AW-1:0];
              state_r <= S_PTR;
            end
            MODE_IND_TGT: begin
              addr_r  <= tgt_w[AW-1:0];
              state_r <= S_TGT;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_PTR: begin
          addr_r <= addr_inc;
          if (cnt_r[0]) begin
            cnt_r   <= 3'd0;
            state_r <= S_PTR_HI;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        S_PTR_HI: begin
          addr_r  <= ptr_w[AW-1:0];
          cnt_r   <= 3'd0;
          state_r <= S_VAL;
        end
        S_TGT: begin
          if (cnt_r[0]) begin
            addr_r  <= op_w[AW-1:0];
            cnt_r   <= 3'd0;
            state_r <= S_VAL;
          end else begin
            addr_r <= addr_inc;
            cnt_r  <= cnt_r + 3'd1;
          end
        end
        S_VAL: begin
          if (cnt_r == last_idx) begin
            state_r <= S_DRAIN;
          end else begin
            addr_r <= addr_inc;
            cnt_r  <= cnt_r + 3'd1;
          end
        end
        S_DRAIN: state_r <= S_DONE;
        S_DONE: begin
          out_item_r.taken   <= nz_r;
          out_item_r.next_pc <= nz_r ? code_offset + dest_r : pc_r + 16'(fall_len);
          state_r            <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign rd.en     = rd_en;
  assign rd.addr   = 16'(addr_r);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `VMCBU_ASSERT_NOW(a_go_idle, go, state_r == S_IDLE, "jump started while sequencer busy")
  `VMCBU_ASSERT_NEXT(a_done_strobe, state_r == S_DONE, out_valid_r, "no strobe after done")
  `VMCBU_ASSERT_NOW(a_strobe_src, out_valid_r, $past(state_r) == S_DONE, "strobe without done")
  `VMCBU_ASSERT_NOW(a_tag_follows, tag_vld_r, $past(rd_en), "read data tagged without a read")
  `VMCBU_ASSERT_NOW(a_val_count, state_r == S_VAL, cnt_r <= last_idx, "value byte count overrun")

endmodule

// File: hw/rtl/vm_conditional_branch_unit.sv
// jump flow: immediate mode reads no memory; direct mode reads the n value bytes; indirect
// target reads two target bytes first, indirect value two pointer bytes (n = 1, 2, 4 or 8);
// reads go through the byte-wide memory read port, one byte per cycle; busy drops as the strobe shows,
// so a new jump is taken only once the previous strobe shows; data writes never raise busy
// synchronous active-low reset clears control and code_offset; data memory stays undefined
module vm_conditional_branch_unit #(
  parameter int unsigned DATA_BYTES = vmcbu_pkg::DATA_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  vmcbu_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output vmcbu_pkg::out_item_t out_item,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);
  import vmcbu_pkg::*;

  logic [15:0] code_offset_r;
  logic        take;
  logic        jump_go;
  mem_wr_t     wr;
  mem_rd_t     rd;
  logic [7:0]  rd_data;

  // code space offset, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_offset_r <= 16'd0;
    end else if (cfg_we) begin
      code_offset_r <= cfg_wdata;
    end
  end

  // an input transfer completes on start with busy low; the receiver cannot stall
  assign take    = start && !busy;
  assign jump_go = take && (in_item.cmd == CMD_JUMP);

  // write items go straight into memory; no jump reads are in flight then
  assign wr.en   = take && (in_item.cmd == CMD_WRITE);
  assign wr.addr = wrap_addr(in_item.write_addr, DATA_BYTES);
  assign wr.data = in_item.write_byte;

  vmcbu_mem #(
    .DATA_BYTES(DATA_BYTES)
  ) u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  // byte-serial walk through pointer, target and value bytes
  vmcbu_seq #(
    .DATA_BYTES(DATA_BYTES)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (jump_go),
    .item        (in_item),
    .code_offset (code_offset_r),
    .busy        (busy),
    .rd          (rd),
    .rd_data     (rd_data),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

endmodule
